FILE: rtl/core/umpcf_pkg.sv
package umpcf_pkg;

  localparam int unsigned CABLES_DEF     = 2;
  localparam int unsigned RING_DEPTH_DEF = 128;

  localparam logic [31:0] SIZE_MAP_RST = 32'h7AFF_E7E0;
  localparam logic [3:0]  CODE_MASK    = 4'h F;

  // Register indexes on the config port
  localparam logic REG_SIZE_MAP = 1'b0;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_DROP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [3:0]      cable;
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } cmd_t;

endpackage

FILE: rtl/core/usb_midi_packet_to_cable_fifos_top.sv
// Channel  | Handshake                 | Payload
// config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (size_map at 0x0)
// in       | in_valid_i / in_ready_o   | kind, header, payload_*, read_cable
// out      | out_valid_o / out_ready_i | out_byte, byte_valid, dropped
//
// Back end per word: a write packet stores one ring byte per cycle through the
// single-port ring RAM, and a read with a byte to return goes through the
// registered RAM read; an empty-ring read and the other words answer from idle.
// Two-entry command queue lets the front accept while the back works.
// The back stalls while the output register holds an untaken word.
// Reset clears indices and reloads the size_map default; ring RAM is not cleared.
module usb_midi_packet_to_cable_fifos_top #(
  parameter int unsigned CABLES     = umpcf_pkg::CABLES_DEF,
  parameter int unsigned RING_DEPTH = umpcf_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  header_i,
  input  logic [7:0]  payload_first_i,
  input  logic [7:0]  payload_second_i,
  input  logic [7:0]  payload_third_i,
  input  logic        read_cable_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        dropped_o
);

  import umpcf_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic head_valid;
  logic pop;

  assign pready = 1'b1;

  umpcf_front #(
    .CABLES (CABLES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .header_i         (header_i),
    .payload_first_i  (payload_first_i),
    .payload_second_i (payload_second_i),
    .payload_third_i  (payload_third_i),
    .read_cable_i     (read_cable_i),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .full_i           (full)
  );

  umpcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  umpcf_back #(
    .CABLES     (CABLES),
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (head_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .dropped_o    (dropped_o)
  );

endmodule

FILE: rtl/core/umpcf_ram.sv
module umpcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/umpcf_front.sv
module umpcf_front #(
  parameter int unsigned CABLES = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         header_i,
  input  logic [7:0]         payload_first_i,
  input  logic [7:0]         payload_second_i,
  input  logic [7:0]         payload_third_i,
  input  logic               read_cable_i,
  output logic               push_o,
  output umpcf_pkg::cmd_t    cmd_o,
  input  logic               full_i
);

  import umpcf_pkg::*;

  logic [31:0] size_map_q, size_map_d;
  logic [1:0]  count;
  logic [3:0]  code;

  always_comb begin
    size_map_d = size_map_q;
    if (psel && penable && pwrite && (paddr[2] == REG_SIZE_MAP)) begin
      size_map_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_map_q <= SIZE_MAP_RST;
    end else begin
      size_map_q <= size_map_d;
    end
  end

  assign prdata = (paddr[2] == REG_SIZE_MAP) ? size_map_q : 32'd0;

  assign code  = header_i[3:0] & CODE_MASK;
  assign count = size_map_q[{code, 1'b0} +: 2];

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.cable = header_i[7:4];
    cmd_o.count = count;
    cmd_o.bytes = {payload_third_i, payload_second_i, payload_first_i};
    if (kind_i) begin
      cmd_o.cable = {3'd0, read_cable_i};
      if ((CABLES > 1) || !read_cable_i) begin
        cmd_o.op = OP_READ;
      end
    end else if (header_i != 8'd0) begin
      if (5'(header_i[7:4]) >= 5'(CABLES)) begin
        cmd_o.op = OP_DROP;
      end else if (count != 2'd0) begin
        cmd_o.op = OP_WRITE;
      end
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

FILE: rtl/core/umpcf_queue.sv
module umpcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  umpcf_pkg::cmd_t cmd_i,
  output logic            full_o,
  output logic            valid_o,
  output umpcf_pkg::cmd_t cmd_o,
  input  logic            pop_i
);

  import umpcf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = slot_q[rd_ptr_q];

endmodule

FILE: rtl/core/umpcf_back.sv
module umpcf_back #(
  parameter int unsigned CABLES     = 2,
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  umpcf_pkg::cmd_t cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            dropped_o
);

  import umpcf_pkg::*;

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (CABLES > 1) ? $clog2(CABLES) : 1;
  localparam int unsigned AW = $clog2(CABLES * RING_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(RING_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WRITE = 3'b010,
    ST_READ  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   wr_idx_q [CABLES];
  logic [IW-1:0]   wr_idx_d [CABLES];
  logic [IW-1:0]   rd_idx_q [CABLES];
  logic [IW-1:0]   rd_idx_d [CABLES];
  logic [CW-1:0]   cab_q, cab_d, cab;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      k_q, k_d;
  logic [2:0][7:0] bytes_q, bytes_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            byte_valid_q, byte_valid_d;
  logic            dropped_q, dropped_d;
  logic            go;
  logic            ram_we;
  logic [IW-1:0]   ram_idx;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + IW'(1);
  endfunction

  assign cab = (state_q == ST_IDLE) ? cmd_i.cable[CW-1:0] : cab_q;
  assign go  = (state_q == ST_IDLE) && cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = go;

  always_comb begin
    state_d      = state_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    cab_d        = cab_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    bytes_d      = bytes_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    dropped_d    = dropped_q;
    ram_we       = 1'b0;
    ram_idx      = wr_idx_q[cab];
    ram_wdata    = cmd_i.bytes[0];
    unique case (state_q)
      ST_IDLE: begin
        if (go) begin
          out_byte_d   = 8'd0;
          byte_valid_d = 1'b0;
          dropped_d    = cmd_i.op == OP_DROP;
          unique case (cmd_i.op)
            OP_WRITE: begin
              out_valid_d   = 1'b1;
              ram_we        = 1'b1;
              wr_idx_d[cab] = next_slot(wr_idx_q[cab]);
              cab_d         = cab;
              cnt_d         = cmd_i.count;
              k_d           = 2'd1;
              bytes_d       = cmd_i.bytes;
              if (cmd_i.count != 2'd1) begin
                state_d = ST_WRITE;
              end
            end
            OP_READ: begin
              ram_idx = rd_idx_q[cab];
              if (rd_idx_q[cab] == wr_idx_q[cab]) begin
                out_valid_d = 1'b1;
              end else begin
                rd_idx_d[cab] = next_slot(rd_idx_q[cab]);
                state_d       = ST_READ;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we        = 1'b1;
        ram_wdata     = bytes_q[k_q];
        wr_idx_d[cab] = next_slot(wr_idx_q[cab]);
        k_d           = k_q + 2'd1;
        if (k_q == cnt_q - 2'd1) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        out_valid_d  = 1'b1;
        out_byte_d   = ram_rdata;
        byte_valid_d = 1'b1;
        dropped_d    = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_addr = AW'(cab) * DEPTH_A + AW'(ram_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CABLES; i++) begin
        wr_idx_q[i] <= '0;
        rd_idx_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cab_q        <= cab_d;
    cnt_q        <= cnt_d;
    k_q          <= k_d;
    bytes_q      <= bytes_d;
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    dropped_q    <= dropped_d;
  end

  umpcf_ram #(
    .WIDTH (8),
    .DEPTH (CABLES * RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign dropped_o    = dropped_q;

endmodule

FILE: sim/tb_usb_midi_packet_to_cable_fifos_top.sv
`timescale 1ns / 1ps

module tb_usb_midi_packet_to_cable_fifos_top;
  import umpcf_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CABLES      = CABLES_DEF;
  localparam int RING_DEPTH  = RING_DEPTH_DEF;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [2:0] SIZE_MAP_ADDR = 3'(4 * REG_SIZE_MAP);

  typedef struct packed {
    logic       kind;
    logic [7:0] header;
    logic [7:0] pay1;
    logic [7:0] pay2;
    logic [7:0] pay3;
    logic       rd_cable;
  } word_t;

  localparam int WORD_W = $bits(word_t);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       drop;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  header_i = '0;
  logic [7:0]  payload_first_i = '0;
  logic [7:0]  payload_second_i = '0;
  logic [7:0]  payload_third_i = '0;
  logic        read_cable_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        dropped_o;

  usb_midi_packet_to_cable_fifos_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .header_i         (header_i),
    .payload_first_i  (payload_first_i),
    .payload_second_i (payload_second_i),
    .payload_third_i  (payload_third_i),
    .read_cable_i     (read_cable_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .dropped_o        (dropped_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow of the block state
  logic [31:0]      map_shadow = SIZE_MAP_RST;
  logic [7:0]       ring_shadow [CABLES][RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr [CABLES] = '{default: '0};
  logic [PTR_W-1:0] rd_ptr [CABLES] = '{default: '0};

  reply_t pending_replies [$];
  int     mismatches = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_req = 0;
  int     hold_ack = 0;
  int     hold_left = 0;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic reply_t predict_reply(word_t w);
    reply_t     r;
    int         cable;
    logic [3:0] code;
    logic [1:0] count;
    logic [7:0] pay [3];
    r = '0;
    pay = '{w.pay1, w.pay2, w.pay3};
    if (!w.kind) begin
      if (w.header != 8'h00) begin
        cable = w.header[7:4];
        code  = w.header[3:0] & CODE_MASK;
        if (cable >= CABLES) begin
          r.drop = 1'b1;
        end else begin
          count = map_shadow[2*code +: 2];
          for (int k = 0; k < count; k++) begin
            ring_shadow[cable][wr_ptr[cable]] = pay[k];
            wr_ptr[cable] = next_ptr(wr_ptr[cable]);
          end
        end
      end
    end else if (w.rd_cable < CABLES && rd_ptr[w.rd_cable] != wr_ptr[w.rd_cable]) begin
      r.data_byte = ring_shadow[w.rd_cable][rd_ptr[w.rd_cable]];
      r.has_byte  = 1'b1;
      rd_ptr[w.rd_cable] = next_ptr(rd_ptr[w.rd_cable]);
    end
    return r;
  endfunction

  function automatic word_t mk(logic kind, logic [7:0] header, logic [7:0] p1,
                               logic [7:0] p2, logic [7:0] p3, logic rc);
    return '{kind, header, p1, p2, p3, rc};
  endfunction

  // cable < 0 picks a built cable at random
  function automatic word_t rand_word(int noise_pct, int write_pct, int cable);
    word_t w;
    int    r;
    int    c;
    w = word_t'(WORD_W'({$urandom, $urandom}));
    c = (cable < 0) ? $urandom_range(CABLES - 1) : cable;
    r = $urandom_range(99);
    if (r < noise_pct) begin
      w.kind = $urandom_range(3) == 0;
      if (!w.kind) begin
        if ($urandom_range(2) == 0) w.header = 8'h00;
        else w.header[7:4] = 4'($urandom_range(15, CABLES));
      end
    end else if (r < noise_pct + write_pct) begin
      w.kind = 1'b0;
      w.header[7:4] = 4'(c);
    end else begin
      w.kind = 1'b1;
      w.rd_cable = 1'(c);
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= w.kind;
    header_i         <= w.header;
    payload_first_i  <= w.pay1;
    payload_second_i <= w.pay2;
    payload_third_i  <= w.pay3;
    read_cable_i     <= w.rd_cable;
    do @(posedge clk_i); while (!in_ready_o);
    pending_replies.push_back(predict_reply(w));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SIZE_MAP_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write size_map (block idle) and read it back
  task automatic set_size_map(logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, value, rdata);
    map_shadow = value;
    @(posedge clk_i);
    apb_access(1'b0, '0, rdata);
    if (rdata !== map_shadow) report_mismatch("size_map readback", rdata, map_shadow);
    @(posedge clk_i);
  endtask

  task automatic test_reset_value;
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== SIZE_MAP_RST) report_mismatch("size_map reset", rdata, SIZE_MAP_RST);
    @(posedge clk_i);
  endtask

  task automatic test_directed;
    word_t words [$];
    words = '{
      mk(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1),  // zero header
      mk(1'b0, 8'h29, 8'h11, 8'h22, 8'h33, 1'b0),  // unbuilt cable
      mk(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1),
      mk(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0),  // empty reads
      mk(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1),
      mk(1'b0, 8'h04, 8'h00, 8'hFF, 8'hAA, 1'b1),
      mk(1'b0, 8'h05, 8'h55, 8'h66, 8'h77, 1'b0),
      mk(1'b0, 8'h02, 8'h01, 8'h80, 8'h99, 1'b1),
      mk(1'b0, 8'h10, 8'hFF, 8'hFF, 8'hFF, 1'b0),  // zero length
      mk(1'b0, 8'h1F, 8'hFE, 8'h01, 8'h02, 1'b0),
      mk(1'b0, 8'h13, 8'h7F, 8'h80, 8'hC3, 1'b1)
    };
    for (int i = 0; i < 7; i++) words.push_back(mk(1'b1, 8'(i * 37), 8'hFF, 8'h00, 8'hFF, 1'b0));
    for (int i = 0; i < 5; i++) words.push_back(mk(1'b1, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1));
    foreach (words[i]) send_word(words[i]);
    drain();
  endtask

  task automatic test_random_mix(int n, int noise_pct, int write_pct);
    for (int i = 0; i < n; i++) send_word(rand_word(noise_pct, write_pct, -1));
    drain();
  endtask

  // write past the ring depth on cable 1, pause, then read back from cables 1 and 0
  task automatic test_overrun;
    for (int i = 0; i < 50; i++) send_word(rand_word(0, 100, 1));
    drain();
    for (int i = 0; i < 30; i++) send_word(rand_word(0, 0, $urandom_range(3) == 0 ? 0 : 1));
    drain();
  endtask

  task automatic test_backpressure;
    hold_req++;
    for (int i = 0; i < 30; i++) send_word(rand_word(10, 55, -1));
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected word", 32'({out_byte_o, byte_valid_o, dropped_o}), '0);
      end else begin
        want = pending_replies.pop_front();
        if (out_byte_o !== want.data_byte) begin
          report_mismatch("out_byte", 32'(out_byte_o), 32'(want.data_byte));
        end
        if (byte_valid_o !== want.has_byte) begin
          report_mismatch("byte_valid", 32'(byte_valid_o), 32'(want.has_byte));
        end
        if (dropped_o !== want.drop) begin
          report_mismatch("dropped", 32'(dropped_o), 32'(want.drop));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 23;
    recv_idle_pct = 80;
    test_reset_value();
    test_directed();
    set_size_map($urandom);
    test_random_mix(150, 15, 50);

    send_idle_pct = 80;
    recv_idle_pct = 23;
    set_size_map(32'hFFFF_FFFF);
    test_overrun();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_size_map(SIZE_MAP_RST);
    test_backpressure();
    set_size_map(32'h0000_0000);
    test_random_mix(30, 10, 50);
    set_size_map(32'h5555_5555);
    test_random_mix(150, 15, 50);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/umpcf_pkg.sv
rtl/core/umpcf_ram.sv
rtl/core/umpcf_front.sv
rtl/core/umpcf_queue.sv
rtl/core/umpcf_back.sv
rtl/core/usb_midi_packet_to_cable_fifos_top.sv
sim/tb_usb_midi_packet_to_cable_fifos_top.sv
